@@ rtl/core/lscp_pkg.sv @@
`timescale 1ns / 1ps
package lscp_pkg;
  localparam int unsigned NumSensors = 5;
  localparam int unsigned SampleBits = 10;
  localparam int unsigned NormBits   = 10;
  localparam int unsigned PosBits    = 9;
  localparam int unsigned FullScale  = 1000;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_CAL   = 2'd1,
    REQ_MEAS  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  localparam logic [0:0] REG_THRESH = 1'b0;
  localparam logic [0:0] REG_LOST   = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [SampleBits-1:0] sample_4;
    logic [SampleBits-1:0] sample_3;
    logic [SampleBits-1:0] sample_2;
    logic [SampleBits-1:0] sample_1;
    logic [SampleBits-1:0] sample_0;
  } in_item_t;

  typedef struct packed {
    logic signed [PosBits-1:0] line_position;
    logic                      line_seen;
    logic [NormBits-1:0] norm_0;
    logic [NormBits-1:0] norm_1;
    logic [NormBits-1:0] norm_2;
    logic [NormBits-1:0] norm_3;
    logic [NormBits-1:0] norm_4;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

  // lane control from sequencer
  typedef struct packed {
    logic start;
    logic clear;
    logic cal;
  } lane_ctrl_t;
endpackage

@@ rtl/core/lscp_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module lscp_div #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q_q, q_d;
  logic [DenW:0]   r_q, r_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {r_q[DenW-1:0], q_q[NumW-1]};
    if (start_i) begin
      q_d = num_i; r_d = '0; cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        r_d = trial - {1'b0, den_q};
        q_d = {q_q[NumW-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d;
    if (start_i) den_q <= den_i;
  end
  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

@@ rtl/core/lscp_lane.sv @@
`timescale 1ns / 1ps
// one sensor channel: calibration range and normalization
module lscp_lane #(
  parameter int unsigned SampleBits = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lscp_pkg::lane_ctrl_t  ctrl_i,
  input  logic [SampleBits-1:0] sample_i,
  output logic                  done_o,
  output logic [9:0]            norm_o
);
  import lscp_pkg::*;
  localparam int unsigned NumW = SampleBits + 10;
  logic [SampleBits-1:0] max_q;
  logic [SampleBits:0]   min_q;
  logic [SampleBits:0]   t, span;
  logic                  flat_q;
  logic [NumW-1:0]       quot;
  logic                  ddone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= {1'b1, {SampleBits{1'b0}}};
    end else if (ctrl_i.clear) begin
      max_q <= '0;
      min_q <= {1'b1, {SampleBits{1'b0}}};
    end else if (ctrl_i.cal) begin
      if (sample_i > max_q) max_q <= sample_i;
      if ({1'b0, sample_i} < min_q) min_q <= {1'b0, sample_i};
    end
  end

  always_comb begin
    t = {1'b0, sample_i};
    if (t < min_q) t = min_q;
    if (t > {1'b0, max_q}) t = {1'b0, max_q};
    span = {1'b0, max_q} - min_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) flat_q <= ({1'b0, max_q} <= min_q);
  end

  lscp_div #(.NumW(NumW), .DenW(SampleBits + 1)) u_div (
    .clk_i, .rst_ni, .start_i(ctrl_i.start),
    .num_i(NumW'(t - min_q) * NumW'(FullScale)),
    .den_i(span), .done_o(ddone), .quot_o(quot)
  );

  assign done_o = ddone;
  assign norm_o = flat_q ? 10'(FullScale) : 10'(FullScale) - quot[9:0];
endmodule

@@ rtl/core/line_sensor_calibrated_position.sv @@
`timescale 1ns / 1ps
// channel   | direction | handshake          | payload
// in        | input     | in_valid/in_ready  | req_type, sample_0..4
// out       | output    | out_valid/out_ready| line_position, line_seen, norm_0..4
// cfg       | input     | apb psel/penable   | on_line_threshold, lost_position
//
// clear and calibrate are taken at the accepting edge and can follow back to back
// measure raises out_valid_o after lane load, the lane divider steps, lane done
// and merge, then mean divider load, its steps and result capture; when no
// channel sees the line the mean divider is skipped
// one item is in flight at a time; the input stays blocked until the result
// transfer
// reset restores calibration, registers and last position at once
module line_sensor_calibrated_position (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lscp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lscp_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lscp_pkg::*;

  localparam int unsigned WsW = 24;
  localparam int unsigned SumW = 13;

  logic [9:0] thresh_q;
  logic [7:0] lost_q;
  logic signed [PosBits-1:0] last_q;
  state_e state_q, state_d;
  out_item_t res_q;
  logic out_valid_q;
  lane_ctrl_t ctrl;
  logic [SampleBits-1:0] samp [NumSensors];
  logic [SampleBits-1:0] samp_q [NumSensors];
  logic [9:0] norm [NumSensors];
  logic [NumSensors-1:0] ldone;
  logic [WsW-1:0] ws_q;
  logic [SumW-1:0] sum_q;
  logic seen_q;
  logic dstart, ddone;
  logic [WsW-1:0] quot;
  logic in_xfer, wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 10'd300; lost_q <= 8'd190;
    end else if (wr) begin
      if (paddr[2] == REG_THRESH) thresh_q <= pwdata[9:0];
      else lost_q <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == REG_THRESH) ? {22'd0, thresh_q} : {24'd0, lost_q};

  assign samp[0] = SampleBits'(in_data_i.sample_0);
  assign samp[1] = SampleBits'(in_data_i.sample_1);
  assign samp[2] = SampleBits'(in_data_i.sample_2);
  assign samp[3] = SampleBits'(in_data_i.sample_3);
  assign samp[4] = SampleBits'(in_data_i.sample_4);

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign in_xfer = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_xfer) samp_q <= samp;
  end

  // lanes, one per sensor
  for (genvar g = 0; g < NumSensors; g++) begin : g_lane
    lane_ctrl_t c;
    always_comb begin
      c = ctrl;
    end
    lscp_lane #(.SampleBits(SampleBits)) u_lane (
      .clk_i, .rst_ni, .ctrl_i(c),
      .sample_i(ctrl.start ? samp_q[g] : samp[g]),
      .done_o(ldone[g]), .norm_o(norm[g])
    );
  end

  // merge stage: weighted and plain sums and the line-seen flag
  logic [WsW-1:0] ws_c;
  logic [SumW-1:0] sum_c;
  logic seen_c;
  always_comb begin
    ws_c = '0; sum_c = '0; seen_c = 1'b0;
    for (int i = 0; i < NumSensors; i++) begin
      ws_c = ws_c + WsW'(norm[i]) * WsW'(i * 100);
      sum_c = sum_c + SumW'(norm[i]);
      if (norm[i] >= thresh_q) seen_c = 1'b1;
    end
  end

  lscp_div #(.NumW(WsW), .DenW(SumW)) u_mean (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(ws_q), .den_i(sum_q),
    .done_o(ddone), .quot_o(quot)
  );

  logic signed [PosBits-1:0] fallback, pos;
  assign fallback = (last_q > 0) ? $signed({1'b0, lost_q}) : -$signed({1'b0, lost_q});
  assign pos = PosBits'(quot) - PosBits'((NumSensors - 1) * 50);

  always_comb begin
    state_d = state_q;
    ctrl = '0;
    dstart = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (req_e'(in_data_i.req_type))
            REQ_CLEAR: ctrl.clear = 1'b1;
            REQ_CAL:   ctrl.cal = 1'b1;
            REQ_MEAS:  state_d = ST_NORM;
            default: ;
          endcase
        end
      end
      ST_NORM: begin
        ctrl.start = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (&ldone) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (seen_q) begin
          dstart = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (ddone) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_valid_q <= 1'b0; last_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_DIV && !seen_q) begin
        out_valid_q <= 1'b1; last_q <= fallback;
      end
      if (state_q == ST_OUT && ddone) begin
        out_valid_q <= 1'b1; last_q <= pos;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM && (&ldone)) begin
      ws_q <= ws_c; sum_q <= sum_c;
      seen_q <= seen_c && (sum_c != '0);
      res_q.norm_0 <= norm[0]; res_q.norm_1 <= norm[1]; res_q.norm_2 <= norm[2];
      res_q.norm_3 <= norm[3]; res_q.norm_4 <= norm[4];
    end
    if (state_q == ST_DIV && !seen_q) begin
      res_q.line_position <= fallback; res_q.line_seen <= 1'b0;
    end
    if (state_q == ST_OUT && ddone) begin
      res_q.line_position <= pos; res_q.line_seen <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = res_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ldone[0]) |-> (&ldone)) else $error("lanes out of step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(res_q)) else $error("result changed");
endmodule
